>>> rtl/core/ima_adpcm_decoder_defines.svh
// Assertion macros used by the checker file of the decoder.
`ifndef IMA_ADPCM_DECODER_DEFINES_SVH
`define IMA_ADPCM_DECODER_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define IMADEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define IMADEC_ASSERT_NEXT(label, ante, cons, msg) \
    `IMADEC_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/core/imadec_pkg.sv
`timescale 1ns / 1ps

package imadec_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_START_SAMPLE = 1'b0;
    localparam logic REG_START_INDEX  = 1'b1;

    localparam logic [6:0] MAX_STEP_INDEX = 7'd88;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       restart;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               second_of_pair;
        logic               block_last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] code;
        logic       restart;
        logic       second;
        logic       block_last;
    } t_nib;

    typedef struct packed {
        logic signed [15:0] start_sample;
        logic [6:0]         start_index;
    } t_cfg;

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    function automatic logic [14:0] step_lookup(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/ima_adpcm_decoder.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                     | Payload
// input    | in        | i_in_valid / o_in_ready       | i_in_item (t_in_item)
// output   | out       | o_out_valid / i_out_ready     | o_out_item (t_out_item)
// config   | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Each item yields two samples, one per cycle unless the output stalls. A new item can
// be taken as the high nibble of the last one is pushed. The limit is the single nibble
// decoder in the back end, which updates the predictor and step index once per cycle
// when not stalled. Reset is synchronous and active low and clears the control state,
// the predictor, the step index and both configuration registers. A stall on the output
// fills the two-entry queue and then holds off new items.

module ima_adpcm_decoder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  imadec_pkg::t_in_item                  i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output imadec_pkg::t_out_item                 o_out_item,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [imadec_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [imadec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [imadec_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    logic [15:0]       r_start_sample;
    logic [6:0]        r_start_index;
    logic              cfg_write;
    imadec_pkg::t_cfg  cfg;

    logic              push;
    logic              can_push;
    imadec_pkg::t_nib  push_nib;
    logic              pop;
    logic              not_empty;
    imadec_pkg::t_nib  head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_sample <= '0;
            r_start_index  <= '0;
        end else if (cfg_write) begin
            case (paddr[2])
                imadec_pkg::REG_START_SAMPLE: r_start_sample <= pwdata[15:0];
                imadec_pkg::REG_START_INDEX:  r_start_index  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            imadec_pkg::REG_START_SAMPLE: prdata = {16'b0, r_start_sample};
            imadec_pkg::REG_START_INDEX:  prdata = {25'b0, r_start_index};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.start_sample = $signed(r_start_sample);
    assign cfg.start_index  = r_start_index;

    imadec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_can_push (can_push),
        .o_push     (push),
        .o_push_nib (push_nib)
    );

    imadec_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_nib  (push_nib),
        .o_can_push  (can_push),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_head      (head)
    );

    imadec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (not_empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/core/imadec_front.sv
`timescale 1ns / 1ps

module imadec_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  imadec_pkg::t_in_item i_in_item,
    input  logic                i_can_push,
    output logic                o_push,
    output imadec_pkg::t_nib    o_push_nib
);

    logic                 r_busy;
    logic                 r_phase;
    imadec_pkg::t_in_item r_item;
    logic                 accept;

    assign o_push     = r_busy && i_can_push;
    assign o_in_ready = !r_busy || (r_phase && o_push);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (r_phase) begin
            o_push_nib.code       = r_item.code_byte[7:4];
            o_push_nib.restart    = 1'b0;
            o_push_nib.second     = 1'b1;
            o_push_nib.block_last = r_item.block_end;
        end else begin
            o_push_nib.code       = r_item.code_byte[3:0];
            o_push_nib.restart    = r_item.restart;
            o_push_nib.second     = 1'b0;
            o_push_nib.block_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (accept) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
        end else if (o_push) begin
            if (r_phase) begin
                r_busy <= 1'b0;
            end
            r_phase <= !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

endmodule

>>> rtl/core/imadec_queue.sv
`timescale 1ns / 1ps

module imadec_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  imadec_pkg::t_nib i_push_nib,
    output logic             o_can_push,
    input  logic             i_pop,
    output logic             o_not_empty,
    output imadec_pkg::t_nib o_head
);

    imadec_pkg::t_nib                     r_mem [imadec_pkg::QUEUE_DEPTH];
    logic [imadec_pkg::QUEUE_PTR_W-1:0]   r_wptr;
    logic [imadec_pkg::QUEUE_PTR_W-1:0]   r_rptr;
    logic [imadec_pkg::QUEUE_CNT_W-1:0]   r_count;
    logic                                 full;

    assign full        = r_count == imadec_pkg::QUEUE_CNT_W'(imadec_pkg::QUEUE_DEPTH);
    assign o_can_push  = !full || i_pop;
    assign o_not_empty = r_count != '0;
    assign o_head      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == imadec_pkg::QUEUE_PTR_W'(imadec_pkg::QUEUE_DEPTH - 1))
                    ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == imadec_pkg::QUEUE_PTR_W'(imadec_pkg::QUEUE_DEPTH - 1))
                    ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_nib;
        end
    end

endmodule

>>> rtl/core/imadec_back.sv
`timescale 1ns / 1ps

module imadec_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_not_empty,
    input  imadec_pkg::t_nib      i_head,
    output logic                  o_pop,
    input  imadec_pkg::t_cfg      i_cfg,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output imadec_pkg::t_out_item o_out_item
);

    logic                  r_out_valid;
    imadec_pkg::t_out_item r_out_item;
    logic signed [15:0]    r_pred;
    logic [6:0]            r_idx;

    logic signed [15:0] cur_pred;
    logic [6:0]         cur_idx;
    logic [6:0]         start_idx;
    logic [14:0]        step;
    logic [16:0]        mag_sum;
    logic signed [17:0] delta;
    logic signed [17:0] sum;
    logic signed [4:0]  adj;
    logic signed [8:0]  idx_sum;
    logic signed [15:0] n_pred;
    logic [6:0]         n_idx;

    assign o_pop       = i_not_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        start_idx = (i_cfg.start_index > imadec_pkg::MAX_STEP_INDEX)
            ? imadec_pkg::MAX_STEP_INDEX : i_cfg.start_index;
        cur_pred  = i_head.restart ? i_cfg.start_sample : r_pred;
        cur_idx   = i_head.restart ? start_idx : r_idx;
        step      = imadec_pkg::step_lookup(cur_idx);

        mag_sum = {5'b0, step[14:3]}
            + (i_head.code[2] ? {2'b0, step} : 17'd0)
            + (i_head.code[1] ? {3'b0, step[14:1]} : 17'd0)
            + (i_head.code[0] ? {4'b0, step[14:2]} : 17'd0);
        delta = i_head.code[3] ? -$signed({1'b0, mag_sum}) : $signed({1'b0, mag_sum});
        sum   = $signed({{2{cur_pred[15]}}, cur_pred}) + delta;

        if (sum > 18'sd32767) begin
            n_pred = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            n_pred = 16'sh8000;
        end else begin
            n_pred = sum[15:0];
        end

        adj     = imadec_pkg::index_adjust(i_head.code[2:0]);
        idx_sum = $signed({2'b0, cur_idx}) + $signed({{4{adj[4]}}, adj});
        if (idx_sum < 9'sd0) begin
            n_idx = 7'd0;
        end else if (idx_sum > $signed({2'b0, imadec_pkg::MAX_STEP_INDEX})) begin
            n_idx = imadec_pkg::MAX_STEP_INDEX;
        end else begin
            n_idx = idx_sum[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pred      <= '0;
            r_idx       <= '0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
            r_pred      <= n_pred;
            r_idx       <= n_idx;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item.pcm_sample     <= n_pred;
            r_out_item.second_of_pair <= i_head.second;
            r_out_item.block_last     <= i_head.block_last;
        end
    end

endmodule

>>> rtl/core/imadec_checker.sv
`timescale 1ns / 1ps
`include "ima_adpcm_decoder_defines.svh"

module imadec_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  imadec_pkg::t_out_item o_out_item
);

    `IMADEC_ASSERT_NEXT(a_out_valid_hold, o_out_valid && !i_out_ready, o_out_valid, "output valid dropped")
    `IMADEC_ASSERT_NEXT(a_out_item_hold, o_out_valid && !i_out_ready, $stable(o_out_item), "output item changed")
    `IMADEC_ASSERT(a_low_not_last, o_out_valid && !o_out_item.second_of_pair |-> !o_out_item.block_last, "low sample marked last")
    `IMADEC_ASSERT_NEXT(a_pair_follows, o_out_valid && i_out_ready && !o_out_item.second_of_pair, o_out_valid && o_out_item.second_of_pair, "high sample did not follow")

endmodule

bind ima_adpcm_decoder imadec_checker u_imadec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
